[hdl/pdf_pkg.sv]
// ----------------------------------------------------------------------------
// pdf_pkg: shared types and constants of the pattern deletion filter
// Counter widths, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int BYTE_W          = 8;
    localparam int PAT_BYTES       = 8;
    localparam int PAT_W           = PAT_BYTES * BYTE_W;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = 4;
    localparam int PATTERN_MAX_DEF = 8;

    localparam logic [0:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [0:0] REG_PATTERN_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } pdf_state_t;

    typedef struct packed {
        logic load;
        logic search_step;
        logic search_done;
        logic push_byte;
        logic push_marker;
    } pdf_cmd_t;

    typedef struct packed {
        logic need_search;
        logic hit;
        logic emit_empty;
        logic emit_last;
        logic fin;
        logic slot_free;
    } pdf_status_t;

endpackage

[hdl/pattern_deletion_filter_top.sv]
// ----------------------------------------------------------------------------
// pattern_deletion_filter_top: streaming substring removal
// Removes every leftmost, non-overlapping occurrence of a pattern of up to
// PATTERN_MAX characters from a byte stream.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item is accepted, then gives its
// results one per cycle unless a stalled receiver holds them up, or passes
// through the emit state when it gives none. A mismatch in the middle of a
// string first runs the fallback, which tries 1 to held count + 1
// candidates and compares one candidate shift per cycle. The final item of
// a string flushes all held characters, or gives a bare end marker when
// nothing is left. Results sit in an output register, so new items are
// taken while the last result waits.
// The pattern is written at index 0 (first character in the low byte) and
// its length at index 1; a length of zero passes everything through.
module pattern_deletion_filter_top
    import pdf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [0:0]        cfg_index,
    input  logic [PAT_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              final_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              byte_valid,
    output logic              last_of_run,
    output logic              end_of_string
);

    pdf_cmd_t    cmd;
    pdf_status_t status;

    pdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pdf_datapath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_byte       (in_byte),
        .final_byte    (final_byte),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run),
        .end_of_string (end_of_string)
    );

endmodule

[hdl/pdf_ctrl.sv]
// ----------------------------------------------------------------------------
// pdf_ctrl: controller of the pattern deletion filter
// Sequences accept, fallback search and release of held characters.
// ----------------------------------------------------------------------------
module pdf_ctrl
    import pdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pdf_status_t status,
    output pdf_cmd_t    cmd
);

    pdf_state_t state_reg;
    pdf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.need_search ? ST_SEARCH : ST_EMIT;
                end
            end
            ST_SEARCH:
            begin
                if (status.hit)
                begin
                    cmd.search_done = 1'b1;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.emit_empty)
                begin
                    // a final item with nothing left still closes the string
                    if (status.fin)
                    begin
                        if (status.slot_free)
                        begin
                            cmd.push_marker = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.slot_free)
                begin
                    cmd.push_byte = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/pdf_datapath.sv]
// ----------------------------------------------------------------------------
// pdf_datapath: datapath of the pattern deletion filter
// Configuration registers, match count, fallback compare lanes and the
// output register.
// ----------------------------------------------------------------------------
module pdf_datapath
    import pdf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [0:0]          cfg_index,
    input  logic [PAT_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                final_byte,
    input  pdf_cmd_t            cmd,
    output pdf_status_t         status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                byte_valid,
    output logic                last_of_run,
    output logic                end_of_string
);

    logic [PAT_W-1:0]  pattern_bytes_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [CNT_W-1:0]  matched_reg;
    logic [CNT_W-1:0]  matched_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;
    logic              out_valid_reg;

    logic [BYTE_W-1:0] c_reg;
    logic              fin_reg;
    logic [CNT_W-1:0]  m_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              byte_valid_reg;
    logic              last_of_run_reg;
    logic              end_of_string_reg;

    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  m_eff;
    logic [CNT_W-1:0]  m_plus;
    logic              in_match;
    logic              lanes_ok;
    logic              emit_last;
    logic              push;

    function automatic logic [BYTE_W-1:0] pat_at(input logic [PAT_W-1:0] pat,
                                                 input logic [CNT_W-1:0] i);
        return pat[i[2:0]*BYTE_W +: BYTE_W];
    endfunction

    // held prefix followed by the current character
    function automatic logic [BYTE_W-1:0] joined_at(input logic [PAT_W-1:0] pat,
                                                    input logic [CNT_W-1:0] i,
                                                    input logic [CNT_W-1:0] m,
                                                    input logic [BYTE_W-1:0] c);
        return (i < m) ? pat_at(pat, i) : c;
    endfunction

    assign len    = (pattern_length_reg > LEN_W'(PATTERN_MAX)) ?
                    CNT_W'(PATTERN_MAX) : pattern_length_reg;
    // a count left over from an older pattern is dropped
    assign m_eff  = (matched_reg >= len) ? '0 : matched_reg;
    assign m_plus = m_eff + CNT_W'(1);
    assign in_match = (pat_at(pattern_bytes_reg, m_eff) == in_byte);

    // one fallback candidate per cycle, all its characters compared at once
    always_comb
    begin
        lanes_ok = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (CNT_W'(i) < k_reg)
            begin
                if (joined_at(pattern_bytes_reg, m_reg + CNT_W'(1) - k_reg + CNT_W'(i),
                              m_reg, c_reg) != pat_at(pattern_bytes_reg, CNT_W'(i)))
                begin
                    lanes_ok = 1'b0;
                end
            end
        end
    end

    assign emit_last = (idx_reg == total_reg - CNT_W'(1));
    assign push      = cmd.push_byte | cmd.push_marker;

    always_comb
    begin
        status.need_search = (len != '0) && !in_match && !final_byte;
        status.hit         = (k_reg == '0) || lanes_ok;
        status.emit_empty  = (total_reg == '0);
        status.emit_last   = emit_last;
        status.fin         = fin_reg;
        status.slot_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        matched_next = matched_reg;
        total_next   = total_reg;
        if (cmd.load)
        begin
            if (len == '0)
            begin
                total_next   = CNT_W'(1);
                matched_next = '0;
            end
            else if (in_match)
            begin
                if (final_byte)
                begin
                    total_next = (m_plus == len) ? '0 : m_plus;
                end
                else
                begin
                    total_next = '0;
                end
                matched_next = (final_byte || m_plus == len) ? '0 : m_plus;
            end
            else if (final_byte)
            begin
                // the suffix kept by the fallback is flushed as well
                total_next   = m_plus;
                matched_next = '0;
            end
        end
        else if (cmd.search_done)
        begin
            total_next   = m_reg + CNT_W'(1) - k_reg;
            matched_next = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            matched_reg        <= '0;
            total_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_PATTERN_BYTES)
                begin
                    pattern_bytes_reg <= cfg_data;
                end
                else if (cfg_index == REG_PATTERN_LENGTH)
                begin
                    pattern_length_reg <= cfg_data[LEN_W-1:0];
                end
            end
            matched_reg <= matched_next;
            total_reg   <= total_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg   <= in_byte;
            fin_reg <= final_byte;
            m_reg   <= m_eff;
            k_reg   <= m_eff;
            idx_reg <= '0;
        end
        if (cmd.search_step)
        begin
            k_reg <= k_reg - CNT_W'(1);
        end
        if (cmd.push_byte)
        begin
            idx_reg           <= idx_reg + CNT_W'(1);
            out_byte_reg      <= joined_at(pattern_bytes_reg, idx_reg, m_reg, c_reg);
            byte_valid_reg    <= 1'b1;
            last_of_run_reg   <= emit_last;
            end_of_string_reg <= emit_last && fin_reg;
        end
        else if (cmd.push_marker)
        begin
            out_byte_reg      <= '0;
            byte_valid_reg    <= 1'b0;
            last_of_run_reg   <= 1'b1;
            end_of_string_reg <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign last_of_run   = last_of_run_reg;
    assign end_of_string = end_of_string_reg;

endmodule
